### hw/rtl/vsf_pkg.sv
// Package for the volume shift block: payload structs, register and operation codes,
// and the helper functions that derive store geometry from the largest dimension.
// No dependencies.
`default_nettype none

package vsf_pkg;

  localparam int unsigned DataWidth     = 32;
  localparam int unsigned SizeWidth     = 6;
  localparam int unsigned ShiftWidth    = 7;
  localparam int unsigned PosWidth      = SizeWidth + 2;
  localparam int unsigned SizeMax       = (2 ** SizeWidth) - 1;
  localparam int unsigned DimMaxDefault = 32;
  localparam int unsigned CfgIdxWidth   = 3;
  localparam int unsigned CfgDataWidth  = 32;
  localparam int unsigned MidDepth      = 4;
  localparam int unsigned OutDepth      = 8;
  localparam int unsigned SettleCycles  = 2;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_SIZE_X    = 3'd0,
    REG_SIZE_Y    = 3'd1,
    REG_SIZE_Z    = 3'd2,
    REG_SHIFT_X   = 3'd3,
    REG_SHIFT_Y   = 3'd4,
    REG_SHIFT_Z   = 3'd5,
    REG_FILL_WORD = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_EMIT = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_MASK  = 2'd2
  } op_e;

  typedef struct packed {
    logic                 req_type;
    logic [DataWidth-1:0] voxel_in;
  } in_t;

  typedef struct packed {
    logic [DataWidth-1:0] voxel_out;
    logic                 last_voxel;
  } out_t;

  // Effective geometry as seen by the datapath: sizes are already clamped.
  typedef struct packed {
    logic        [SizeWidth-1:0]  size_x;
    logic        [SizeWidth-1:0]  size_y;
    logic        [SizeWidth-1:0]  size_z;
    logic signed [ShiftWidth-1:0] shift_x;
    logic signed [ShiftWidth-1:0] shift_y;
    logic signed [ShiftWidth-1:0] shift_z;
    logic        [DataWidth-1:0]  fill_word;
  } cfg_t;

  function automatic int unsigned eff_max(int unsigned dim_max);
    return (dim_max < SizeMax) ? dim_max : SizeMax;
  endfunction

  function automatic int unsigned store_depth(int unsigned dim_max);
    return eff_max(dim_max) * eff_max(dim_max) * eff_max(dim_max);
  endfunction

  function automatic int unsigned coord_width(int unsigned dim_max);
    return $clog2(eff_max(dim_max));
  endfunction

  function automatic int unsigned addr_width(int unsigned dim_max);
    return $clog2(store_depth(dim_max));
  endfunction

  function automatic int unsigned count_width(int unsigned dim_max);
    return $clog2(store_depth(dim_max) + 1);
  endfunction

  function automatic int unsigned op_width(int unsigned dim_max);
    return 2 + addr_width(dim_max) + 3 * coord_width(dim_max) + DataWidth + 1;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/vsf_fifo.sv
// Small first-word-fall-through queue built from registers.
// Depends on nothing; used between the front and back parts and on the result side.
`default_nettype none

module vsf_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [Width-1:0]           data_i,
  input  logic                       pop_i,
  output logic [Width-1:0]           data_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);

  logic [Width-1:0]    mem_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == CntWidth'(Depth));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_q + PtrWidth'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_q + PtrWidth'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntWidth'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/vsf_front.sv
// Front part: classifies each accepted item, keeps the load count and the emit position,
// and issues store writes, store reads or fill operations. Depends on vsf_pkg.
`default_nettype none

module vsf_front #(
  parameter int unsigned DimMax = vsf_pkg::DimMaxDefault
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  vsf_pkg::cfg_t                              cfg_i,
  input  logic [vsf_pkg::count_width(DimMax)-1:0]    total_i,
  input  logic                                       valid_i,
  input  vsf_pkg::in_t                               item_i,
  output logic                                       op_valid_o,
  output logic [vsf_pkg::op_width(DimMax)-1:0]       op_o
);

  localparam int unsigned CoordWidth = vsf_pkg::coord_width(DimMax);
  localparam int unsigned AddrWidth  = vsf_pkg::addr_width(DimMax);
  localparam int unsigned CountWidth = vsf_pkg::count_width(DimMax);
  localparam int unsigned SizeWidth  = vsf_pkg::SizeWidth;
  localparam int unsigned PosWidth   = vsf_pkg::PosWidth;

  typedef struct packed {
    vsf_pkg::op_e                   kind;
    logic [AddrWidth-1:0]           waddr;
    logic [CoordWidth-1:0]          px;
    logic [CoordWidth-1:0]          py;
    logic [CoordWidth-1:0]          pz;
    logic [vsf_pkg::DataWidth-1:0]  data;
    logic                           last;
  } op_t;

  logic [CountWidth-1:0] load_count_q, load_count_d;
  logic [CoordWidth-1:0] emit_x_q, emit_x_d;
  logic [CoordWidth-1:0] emit_y_q, emit_y_d;
  logic [CoordWidth-1:0] emit_z_q, emit_z_d;

  logic                       loaded, is_emit, wrap;
  logic [SizeWidth-1:0]       cur_x, cur_y, cur_z;
  logic [SizeWidth-1:0]       inc_x, inc_y, inc_z;
  logic signed [PosWidth-1:0] px_s, py_s, pz_s;
  logic                       in_vol;
  op_t                        op;

  assign loaded  = (load_count_q >= total_i);
  assign is_emit = (vsf_pkg::req_e'(item_i.req_type) == vsf_pkg::REQ_EMIT);
  assign wrap    = (SizeWidth'(emit_x_q) >= cfg_i.size_x) ||
                   (SizeWidth'(emit_y_q) >= cfg_i.size_y) ||
                   (SizeWidth'(emit_z_q) >= cfg_i.size_z);

  always_comb begin
    cur_x = wrap ? '0 : SizeWidth'(emit_x_q);
    cur_y = wrap ? '0 : SizeWidth'(emit_y_q);
    cur_z = wrap ? '0 : SizeWidth'(emit_z_q);
    inc_x = cur_x + SizeWidth'(1);
    inc_y = cur_y + SizeWidth'(1);
    inc_z = cur_z + SizeWidth'(1);

    px_s = $signed({2'b00, cur_x}) - PosWidth'($signed(cfg_i.shift_x));
    py_s = $signed({2'b00, cur_y}) - PosWidth'($signed(cfg_i.shift_y));
    pz_s = $signed({2'b00, cur_z}) - PosWidth'($signed(cfg_i.shift_z));
    in_vol = (px_s >= 0) && (px_s < $signed({2'b00, cfg_i.size_x})) &&
             (py_s >= 0) && (py_s < $signed({2'b00, cfg_i.size_y})) &&
             (pz_s >= 0) && (pz_s < $signed({2'b00, cfg_i.size_z}));

    op.kind  = is_emit ? (in_vol ? vsf_pkg::OP_READ : vsf_pkg::OP_MASK) : vsf_pkg::OP_WRITE;
    op.waddr = load_count_q[AddrWidth-1:0];
    op.px    = px_s[CoordWidth-1:0];
    op.py    = py_s[CoordWidth-1:0];
    op.pz    = pz_s[CoordWidth-1:0];
    op.data  = is_emit ? cfg_i.fill_word : item_i.voxel_in;
    op.last  = (cur_x == cfg_i.size_x - SizeWidth'(1)) &&
               (cur_y == cfg_i.size_y - SizeWidth'(1)) &&
               (cur_z == cfg_i.size_z - SizeWidth'(1));

    load_count_d = load_count_q;
    emit_x_d     = emit_x_q;
    emit_y_d     = emit_y_q;
    emit_z_d     = emit_z_q;
    if (valid_i && !is_emit && !loaded) begin
      load_count_d = load_count_q + CountWidth'(1);
    end
    if (valid_i && is_emit && loaded) begin
      emit_x_d = '0;
      emit_y_d = cur_y[CoordWidth-1:0];
      emit_z_d = cur_z[CoordWidth-1:0];
      if (inc_x < cfg_i.size_x) begin
        emit_x_d = inc_x[CoordWidth-1:0];
      end else if (inc_y < cfg_i.size_y) begin
        emit_y_d = inc_y[CoordWidth-1:0];
      end else begin
        emit_y_d = '0;
        emit_z_d = (inc_z < cfg_i.size_z) ? inc_z[CoordWidth-1:0] : '0;
      end
    end
  end

  assign op_valid_o = valid_i && (is_emit ? loaded : !loaded);
  assign op_o       = op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_count_q <= '0;
      emit_x_q     <= '0;
      emit_y_q     <= '0;
      emit_z_q     <= '0;
    end else begin
      load_count_q <= load_count_d;
      emit_x_q     <= emit_x_d;
      emit_y_q     <= emit_y_d;
      emit_z_q     <= emit_z_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/vsf_back.sv
// Back part: address pipeline (two multiply stages) and the voxel store with a registered
// read port; takes operations only while the result queue has room. Depends on vsf_pkg.
`default_nettype none

module vsf_back #(
  parameter int unsigned DimMax = vsf_pkg::DimMaxDefault
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic [vsf_pkg::SizeWidth-1:0]                  size_x_i,
  input  logic [vsf_pkg::SizeWidth-1:0]                  size_y_i,
  input  logic                                           op_valid_i,
  input  logic [vsf_pkg::op_width(DimMax)-1:0]           op_i,
  input  logic [$clog2(vsf_pkg::OutDepth+1)-1:0]         out_count_i,
  output logic                                           take_o,
  output logic                                           res_valid_o,
  output vsf_pkg::out_t                                  res_o
);

  localparam int unsigned CoordWidth = vsf_pkg::coord_width(DimMax);
  localparam int unsigned AddrWidth  = vsf_pkg::addr_width(DimMax);
  localparam int unsigned StoreDepth = vsf_pkg::store_depth(DimMax);
  localparam int unsigned EffMax     = vsf_pkg::eff_max(DimMax);
  localparam int unsigned SizeWidth  = vsf_pkg::SizeWidth;
  localparam int unsigned DataWidth  = vsf_pkg::DataWidth;
  localparam int unsigned RowWidth   = $clog2(EffMax * EffMax);
  localparam int unsigned Mul1Width  = CoordWidth + SizeWidth + 1;
  localparam int unsigned Mul2Width  = RowWidth + SizeWidth + 1;
  localparam int unsigned OutCntW    = $clog2(vsf_pkg::OutDepth + 1);

  typedef struct packed {
    vsf_pkg::op_e           kind;
    logic [AddrWidth-1:0]   waddr;
    logic [CoordWidth-1:0]  px;
    logic [CoordWidth-1:0]  py;
    logic [CoordWidth-1:0]  pz;
    logic [DataWidth-1:0]   data;
    logic                   last;
  } op_t;

  op_t op;

  logic                  s1_valid_q;
  vsf_pkg::op_e          s1_kind_q;
  logic [RowWidth-1:0]   s1_row_q;
  logic [CoordWidth-1:0] s1_px_q;
  logic [AddrWidth-1:0]  s1_waddr_q;
  logic [DataWidth-1:0]  s1_data_q;
  logic                  s1_last_q;

  logic                  s2_valid_q;
  vsf_pkg::op_e          s2_kind_q;
  logic [AddrWidth-1:0]  s2_addr_q;
  logic [DataWidth-1:0]  s2_data_q;
  logic                  s2_last_q;

  logic                  s3_valid_q;
  vsf_pkg::op_e          s3_kind_q;
  logic [DataWidth-1:0]  s3_data_q;
  logic                  s3_last_q;
  logic [DataWidth-1:0]  rdata_q;

  logic [DataWidth-1:0]  mem_q [StoreDepth];

  logic [Mul1Width-1:0]  row_full;
  logic [Mul2Width-1:0]  addr_full;
  logic [AddrWidth-1:0]  addr_d;
  logic [OutCntW:0]      pending;

  assign op = op_t'(op_i);

  assign pending = {1'b0, out_count_i} + (OutCntW + 1)'(s1_valid_q) +
                   (OutCntW + 1)'(s2_valid_q) + (OutCntW + 1)'(s3_valid_q);
  assign take_o  = op_valid_i && (pending < (OutCntW + 1)'(vsf_pkg::OutDepth));

  assign row_full  = Mul1Width'(op.pz) * Mul1Width'(size_y_i) + Mul1Width'(op.py);
  assign addr_full = Mul2Width'(s1_row_q) * Mul2Width'(size_x_i) + Mul2Width'(s1_px_q);

  always_comb begin
    case (s1_kind_q)
      vsf_pkg::OP_WRITE: addr_d = s1_waddr_q;
      vsf_pkg::OP_READ:  addr_d = addr_full[AddrWidth-1:0];
      default:           addr_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= take_o;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_kind_q  <= op.kind;
    s1_row_q   <= row_full[RowWidth-1:0];
    s1_px_q    <= op.px;
    s1_waddr_q <= op.waddr;
    s1_data_q  <= op.data;
    s1_last_q  <= op.last;
    s2_kind_q  <= s1_kind_q;
    s2_addr_q  <= addr_d;
    s2_data_q  <= s1_data_q;
    s2_last_q  <= s1_last_q;
    s3_kind_q  <= s2_kind_q;
    s3_data_q  <= s2_data_q;
    s3_last_q  <= s2_last_q;
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && (s2_kind_q == vsf_pkg::OP_WRITE)) begin
      mem_q[s2_addr_q] <= s2_data_q;
    end
    if (s2_valid_q && (s2_kind_q == vsf_pkg::OP_READ)) begin
      rdata_q <= mem_q[s2_addr_q];
    end
  end

  assign res_valid_o     = s3_valid_q && (s3_kind_q != vsf_pkg::OP_WRITE);
  assign res_o.voxel_out = (s3_kind_q == vsf_pkg::OP_READ) ? rdata_q : s3_data_q;
  assign res_o.last_voxel = s3_last_q;

endmodule

`default_nettype wire

### hw/rtl/volume_shift_with_fill.sv
// Top level of the volume shift block: configuration registers, clamped geometry and
// voxel count, and the front part, queues and back part. Depends on vsf_pkg, vsf_fifo,
// vsf_front and vsf_back.
//
// Usage: items enter through a queue-like port (push, full, in_data_i). A load item
// writes the next voxel of the volume in raster order; an emit item produces one
// translated voxel on the result port (empty, pop, out_data_o) once the whole volume
// has been loaded. Loads, surplus loads and early emits give no result.
// Throughput is one item per clock cycle while full stays low, set by the single store port and the
// counter updates in the front part. An emit's result passes through the operation queue,
// the address multiplier stages and the registered store read into the result queue.
// Registers are written through cfg_we_i, cfg_idx_i and cfg_wdata_i; after a write, and
// after reset, full stays high while the voxel count settles.
// Reset clears the load count and emit position and restores the register defaults;
// the store contents are not cleared. When the receiver stalls, the eight-entry
// result queue fills, then the four-entry operation queue, and full then rises.
`default_nettype none

module volume_shift_with_fill #(
  parameter int unsigned DimMax = vsf_pkg::DimMaxDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  vsf_pkg::in_t                        in_data_i,
  output logic                                empty,
  input  logic                                pop,
  output vsf_pkg::out_t                       out_data_o,
  input  logic                                cfg_we_i,
  input  logic [vsf_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [vsf_pkg::CfgDataWidth-1:0]    cfg_wdata_i
);

  localparam int unsigned SizeWidth  = vsf_pkg::SizeWidth;
  localparam int unsigned ShiftWidth = vsf_pkg::ShiftWidth;
  localparam int unsigned EffMax     = vsf_pkg::eff_max(DimMax);
  localparam int unsigned CountWidth = vsf_pkg::count_width(DimMax);
  localparam int unsigned OpWidth    = vsf_pkg::op_width(DimMax);
  localparam int unsigned NxyWidth   = $clog2(EffMax * EffMax + 1);
  localparam int unsigned OutWidth   = $bits(vsf_pkg::out_t);
  localparam int unsigned OutCntW    = $clog2(vsf_pkg::OutDepth + 1);
  localparam int unsigned SettleW    = $clog2(vsf_pkg::SettleCycles + 1);

  logic [SizeWidth-1:0]          size_x_q, size_y_q, size_z_q;
  logic [ShiftWidth-1:0]         shift_x_q, shift_y_q, shift_z_q;
  logic [vsf_pkg::DataWidth-1:0] fill_word_q;
  logic [SettleW-1:0]            settle_q;
  logic [NxyWidth-1:0]           nxy_q;
  logic [CountWidth-1:0]         total_q;

  vsf_pkg::cfg_t                 eff_cfg;
  logic [2*SizeWidth-1:0]        nxy_full;
  logic [NxyWidth+SizeWidth-1:0] total_full;

  logic                 accept;
  logic                 op_valid, mid_full, mid_empty, take;
  logic [OpWidth-1:0]   op_in, op_out;
  logic [$clog2(vsf_pkg::MidDepth+1)-1:0] mid_count;
  logic                 res_valid, out_full;
  vsf_pkg::out_t        res;
  logic [OutWidth-1:0]  out_raw;
  logic [OutCntW-1:0]   out_count;

  function automatic logic [SizeWidth-1:0] clamp_size(logic [SizeWidth-1:0] raw);
    if (raw == '0) begin
      return SizeWidth'(1);
    end else if (raw > SizeWidth'(EffMax)) begin
      return SizeWidth'(EffMax);
    end
    return raw;
  endfunction

  always_comb begin
    eff_cfg.size_x    = clamp_size(size_x_q);
    eff_cfg.size_y    = clamp_size(size_y_q);
    eff_cfg.size_z    = clamp_size(size_z_q);
    eff_cfg.shift_x   = shift_x_q;
    eff_cfg.shift_y   = shift_y_q;
    eff_cfg.shift_z   = shift_z_q;
    eff_cfg.fill_word = fill_word_q;
  end

  assign nxy_full   = eff_cfg.size_x * eff_cfg.size_y;
  assign total_full = nxy_q * eff_cfg.size_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q    <= SizeWidth'(32);
      size_y_q    <= SizeWidth'(32);
      size_z_q    <= SizeWidth'(32);
      shift_x_q   <= '0;
      shift_y_q   <= '0;
      shift_z_q   <= '0;
      fill_word_q <= '0;
      settle_q    <= SettleW'(vsf_pkg::SettleCycles);
    end else begin
      if (cfg_we_i) begin
        settle_q <= SettleW'(vsf_pkg::SettleCycles);
        case (vsf_pkg::cfg_reg_e'(cfg_idx_i))
          vsf_pkg::REG_SIZE_X:    size_x_q    <= cfg_wdata_i[SizeWidth-1:0];
          vsf_pkg::REG_SIZE_Y:    size_y_q    <= cfg_wdata_i[SizeWidth-1:0];
          vsf_pkg::REG_SIZE_Z:    size_z_q    <= cfg_wdata_i[SizeWidth-1:0];
          vsf_pkg::REG_SHIFT_X:   shift_x_q   <= cfg_wdata_i[ShiftWidth-1:0];
          vsf_pkg::REG_SHIFT_Y:   shift_y_q   <= cfg_wdata_i[ShiftWidth-1:0];
          vsf_pkg::REG_SHIFT_Z:   shift_z_q   <= cfg_wdata_i[ShiftWidth-1:0];
          vsf_pkg::REG_FILL_WORD: fill_word_q <= cfg_wdata_i[vsf_pkg::DataWidth-1:0];
          default: ;
        endcase
      end else if (settle_q != '0) begin
        settle_q <= settle_q - SettleW'(1);
      end
    end
  end

  // The voxel count is built in nxy_q and then total_q; full stays high while it settles.
  always_ff @(posedge clk_i) begin
    nxy_q   <= nxy_full[NxyWidth-1:0];
    total_q <= total_full[CountWidth-1:0];
  end

  assign full   = mid_full || (settle_q != '0);
  assign accept = push && !full;

  vsf_front #(
    .DimMax (DimMax)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (eff_cfg),
    .total_i    (total_q),
    .valid_i    (accept),
    .item_i     (in_data_i),
    .op_valid_o (op_valid),
    .op_o       (op_in)
  );

  vsf_fifo #(
    .Width (OpWidth),
    .Depth (vsf_pkg::MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_valid),
    .data_i  (op_in),
    .pop_i   (take),
    .data_o  (op_out),
    .full_o  (mid_full),
    .empty_o (mid_empty),
    .count_o (mid_count)
  );

  vsf_back #(
    .DimMax (DimMax)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .size_x_i    (eff_cfg.size_x),
    .size_y_i    (eff_cfg.size_y),
    .op_valid_i  (!mid_empty && (mid_count != '0)),
    .op_i        (op_out),
    .out_count_i (out_count),
    .take_o      (take),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  vsf_fifo #(
    .Width (OutWidth),
    .Depth (vsf_pkg::OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .pop_i   (pop),
    .data_o  (out_raw),
    .full_o  (out_full),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign out_data_o = vsf_pkg::out_t'(out_raw);

endmodule

`default_nettype wire

### hw/rtl/vsf_checker.sv
// Port-level checks for the volume shift block, attached to the top level by bind.
// Depends on vsf_pkg and volume_shift_with_fill.
`default_nettype none

module vsf_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          full,
  input logic          empty,
  input logic          pop,
  input vsf_pkg::out_t out_data_o,
  input logic          cfg_we_i
);

  // After a register write, full stays high while the voxel count settles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> full ##1 full)
    else $error("input side open too soon after a register write");

  // A result that is not taken stays on the ports unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_data_o)))
    else $error("waiting result changed or vanished before its transfer");

  // Reset empties the result queue.
  assert property (@(posedge clk_i)
    !rst_ni |-> empty)
    else $error("result queue not empty during reset");

  // Nothing can reach the result side in the cycle reset is released.
  assert property (@(posedge clk_i)
    $past(!rst_ni) |-> empty)
    else $error("result shown straight after reset");

endmodule

bind volume_shift_with_fill vsf_checker u_vsf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_data_o (out_data_o),
  .cfg_we_i   (cfg_we_i)
);

`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for volume_shift_with_fill: loads and emits voxel volumes under
// many shift and size settings and checks every emitted voxel against a behavioural model.
// Depends on vsf_pkg and the volume_shift_with_fill RTL.
`timescale 1ns / 1ps

module testbench;
  import vsf_pkg::*;

  localparam int unsigned DimMax     = DimMaxDefault;
  localparam int unsigned ItemTarget = 1550;
  localparam int unsigned MaxVolume  = 256;
  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned SettleWait = 8;

  logic                    clk_i;
  logic                    rst_ni    = 1'b0;
  logic                    push      = 1'b0;
  logic                    full;
  in_t                     voxel_req = '0;
  logic                    empty;
  logic                    pop       = 1'b0;
  out_t                    voxel_res;
  logic                    cfg_we    = 1'b0;
  cfg_reg_e                cfg_idx   = REG_SIZE_X;
  logic [CfgDataWidth-1:0] cfg_wdata = '0;

  volume_shift_with_fill DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (voxel_req),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (voxel_res),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // Shadow copy of the block's registers and state.
  logic        [SizeWidth-1:0]  dim_q   [3] = '{6'd32, 6'd32, 6'd32};
  logic signed [ShiftWidth-1:0] shift_q [3] = '{7'sd0, 7'sd0, 7'sd0};
  logic        [DataWidth-1:0]  fill_word   = '0;
  logic        [DataWidth-1:0]  voxel_mem [DimMax*DimMax*DimMax];
  int unsigned                  loaded      = 0;
  int unsigned                  pos_x       = 0;
  int unsigned                  pos_y       = 0;
  int unsigned                  pos_z       = 0;

  in_t         pending_items[$];
  out_t        expected_voxels[$];
  out_t        want;
  int unsigned fail_count   = 0;
  int unsigned send_wait    = 0;
  int unsigned recv_wait    = 0;
  int unsigned recv_gap;
  int unsigned quiet_cycles = 0;
  bit          send_calm    = 1'b0;
  bit          recv_calm    = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_dim(logic [SizeWidth-1:0] raw);
    if (raw == 0) return 1;
    if (raw > DimMax) return DimMax;
    return raw;
  endfunction

  function automatic void predict_transfer(input in_t item);
    int   nx, ny, nz, total, px, py, pz;
    out_t res;
    nx    = clamp_dim(dim_q[0]);
    ny    = clamp_dim(dim_q[1]);
    nz    = clamp_dim(dim_q[2]);
    total = nx * ny * nz;
    if (item.req_type == REQ_LOAD) begin
      if (loaded < total) begin
        voxel_mem[loaded] = item.voxel_in;
        loaded++;
      end
      return;
    end
    if (loaded < total) return;
    if (pos_x >= nx || pos_y >= ny || pos_z >= nz) begin
      pos_x = 0;
      pos_y = 0;
      pos_z = 0;
    end
    px = int'(pos_x) - int'(shift_q[0]);
    py = int'(pos_y) - int'(shift_q[1]);
    pz = int'(pos_z) - int'(shift_q[2]);
    if (px >= 0 && px < nx && py >= 0 && py < ny && pz >= 0 && pz < nz) begin
      res.voxel_out = voxel_mem[(pz * ny + py) * nx + px];
    end else begin
      res.voxel_out = fill_word;
    end
    res.last_voxel = (pos_x == nx - 1) && (pos_y == ny - 1) && (pos_z == nz - 1);
    if (pos_x + 1 < nx) begin
      pos_x++;
    end else begin
      pos_x = 0;
      if (pos_y + 1 < ny) begin
        pos_y++;
      end else begin
        pos_y = 0;
        pos_z = (pos_z + 1 < nz) ? pos_z + 1 : 0;
      end
    end
    expected_voxels.push_back(res);
  endfunction

  // Request side: one transfer per item, with a drawn pause before the next.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push      <= 1'b0;
      voxel_req <= '0;
      send_wait <= 0;
    end else if (!push || !full) begin
      if (send_wait != 0) begin
        push      <= 1'b0;
        send_wait <= send_wait - 1;
      end else if (pending_items.size() != 0) begin
        push      <= 1'b1;
        voxel_req <= pending_items.pop_front();
        send_wait <= send_calm ? 0 : $urandom_range(0, 4);
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Watches both sides: predicts on each request transfer, checks each result transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop       <= 1'b0;
      recv_wait <= 0;
    end else begin
      if (push && !full) predict_transfer(voxel_req);
      if (pop && !empty) begin
        if (expected_voxels.size() == 0) begin
          $error("result with no expectation waiting: voxel_out %h, last_voxel %b",
                 voxel_res.voxel_out, voxel_res.last_voxel);
          fail_count++;
        end else begin
          want = expected_voxels.pop_front();
          if (voxel_res.voxel_out !== want.voxel_out) begin
            $error("voxel_out: expected %h, got %h", want.voxel_out, voxel_res.voxel_out);
            fail_count++;
          end
          if (voxel_res.last_voxel !== want.last_voxel) begin
            $error("last_voxel: expected %b, got %b", want.last_voxel, voxel_res.last_voxel);
            fail_count++;
          end
        end
        recv_gap  = recv_calm ? 0 : $urandom_range(0, 4);
        pop       <= (recv_gap == 0);
        recv_wait <= (recv_gap == 0) ? 0 : recv_gap - 1;
      end else if (recv_wait != 0) begin
        recv_wait <= recv_wait - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_item(input req_e kind, input logic [DataWidth-1:0] word);
    in_t item;
    item.req_type = kind;
    item.voxel_in = word;
    pending_items.push_back(item);
  endtask

  task automatic wait_quiet();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || push || expected_voxels.size() != 0);
    repeat (SettleWait) @(negedge clk_i);
  endtask

  task automatic put_reg(input cfg_reg_e idx, input logic [CfgDataWidth-1:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
  endtask

  task automatic configure(input logic [SizeWidth-1:0] nx, ny, nz,
                           input logic signed [ShiftWidth-1:0] shx, shy, shz,
                           input logic [DataWidth-1:0] tag);
    wait_quiet();
    dim_q     = '{nx, ny, nz};
    shift_q   = '{shx, shy, shz};
    fill_word = tag;
    put_reg(REG_SIZE_X, CfgDataWidth'(nx));
    put_reg(REG_SIZE_Y, CfgDataWidth'(ny));
    put_reg(REG_SIZE_Z, CfgDataWidth'(nz));
    put_reg(REG_SHIFT_X, CfgDataWidth'(shx));
    put_reg(REG_SHIFT_Y, CfgDataWidth'(shy));
    put_reg(REG_SHIFT_Z, CfgDataWidth'(shz));
    put_reg(REG_FILL_WORD, tag);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [SizeWidth-1:0] pick_size();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll < 3) return SizeWidth'($urandom_range(7, 63));
    return SizeWidth'($urandom_range(1, 6));
  endfunction

  function automatic logic signed [ShiftWidth-1:0] pick_shift(input int unsigned n);
    if ($urandom_range(0, 3) == 0) return ShiftWidth'($urandom);
    return ShiftWidth'(int'($urandom_range(0, 2 * n)) - int'(n));
  endfunction

  initial begin
    logic [SizeWidth-1:0]         dims [3];
    logic signed [ShiftWidth-1:0] shifts [3];
    logic [DataWidth-1:0]         tag;
    int unsigned                  roll, phase, sent_items, total, n_emit;
    int                           loads_needed;
    phase      = 0;
    sent_items = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset geometry: an emit before the volume is loaded, then a first load.
    queue_item(REQ_EMIT, 32'hFFFF_FFFF);
    queue_item(REQ_LOAD, 32'h0000_0000);

    // Two by two volume: fill it, try one load too many, then emit past the wrap.
    configure(6'd2, 6'd2, 6'd1, 7'sd0, 7'sd0, 7'sd0, 32'hFFFF_FFFF);
    queue_item(REQ_LOAD, 32'hFFFF_FFFF);
    queue_item(REQ_LOAD, $urandom);
    queue_item(REQ_LOAD, $urandom);
    queue_item(REQ_LOAD, 32'h1234_5678);
    repeat (5) queue_item(REQ_EMIT, $urandom);

    configure(6'd2, 6'd2, 6'd1, 7'sd1, -7'sd1, 7'sd0, 32'h0000_0000);
    repeat (4) queue_item(REQ_EMIT, $urandom);

    // Shrinking x leaves the emit position outside, so it restarts at the origin.
    configure(6'd1, 6'd2, 6'd1, 7'sd0, 7'sd0, 7'sd0, 32'hA5A5_A5A5);
    repeat (2) queue_item(REQ_EMIT, $urandom);

    // Zero sizes count as one; shifts beyond the volume give only the fill word.
    configure(6'd0, 6'd0, 6'd0, 7'sd32, 7'sh40, 7'sd63, 32'hFFFF_0000);
    repeat (2) queue_item(REQ_EMIT, $urandom);

    configure(6'd0, 6'd0, 6'd0, 7'sd0, 7'sd0, 7'sd0, 32'h0000_FFFF);
    queue_item(REQ_EMIT, $urandom);

    while (sent_items < ItemTarget) begin
      phase++;
      if (phase % 4 == 0) begin
        foreach (dims[i]) dims[i] = SizeWidth'($urandom_range(0, 2));
        dims[(phase / 4) % 3] = SizeWidth'($urandom_range(32, 63));
      end else begin
        do begin
          foreach (dims[i]) dims[i] = pick_size();
        end while (clamp_dim(dims[0]) * clamp_dim(dims[1]) * clamp_dim(dims[2]) > MaxVolume);
      end
      foreach (shifts[i]) shifts[i] = pick_shift(clamp_dim(dims[i]));
      roll = $urandom_range(0, 7);
      tag  = (roll == 0) ? '0 : (roll == 1) ? '1 : DataWidth'($urandom);
      configure(dims[0], dims[1], dims[2], shifts[0], shifts[1], shifts[2], tag);
      send_calm = ($urandom_range(0, 3) == 0);
      recv_calm = ($urandom_range(0, 3) == 0);

      total        = clamp_dim(dims[0]) * clamp_dim(dims[1]) * clamp_dim(dims[2]);
      loads_needed = int'(total) - int'(loaded);
      for (int i = 0; i < loads_needed; i++) begin
        if ($urandom_range(0, 6) == 0) begin
          queue_item(REQ_EMIT, $urandom);
          sent_items++;
        end
        queue_item(REQ_LOAD, $urandom);
      end
      n_emit = $urandom_range(total / 2 + 1, 2 * total + 1);
      if (n_emit > 150) n_emit = 150;
      for (int i = 0; i < n_emit; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          queue_item(REQ_LOAD, $urandom);
          sent_items++;
        end
        queue_item(REQ_EMIT, $urandom);
      end
      sent_items += n_emit + ((loads_needed > 0) ? loads_needed : 0);
    end

    wait_quiet();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/vsf_pkg.sv
hw/rtl/vsf_fifo.sv
hw/rtl/vsf_front.sv
hw/rtl/vsf_back.sv
hw/rtl/volume_shift_with_fill.sv
hw/rtl/vsf_checker.sv
verif/testbench.sv
